// ----- design/safe_mode_check_pattern_finder_top_macros.svh -----
// ----------------------------------------------------------------------------
// safe mode check pattern finder assertion macros
// shared assertion wrappers for the pattern finder modules
// ----------------------------------------------------------------------------
`ifndef SAFE_MODE_CHECK_PATTERN_FINDER_TOP_MACROS_SVH
`define SAFE_MODE_CHECK_PATTERN_FINDER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define SMCPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define SMCPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/smcpf_pkg.sv -----
// ----------------------------------------------------------------------------
// smcpf_pkg
// types, constants and helpers shared by the pattern finder modules
// ----------------------------------------------------------------------------
`default_nettype none

package smcpf_pkg;

   // geometry of the scan
   localparam int MATCH_DISTANCE = 16;
   localparam int OFFSET_BITS    = 24;
   localparam int WIN            = 4 + MATCH_DISTANCE;
   localparam int SIZE_BITS      = OFFSET_BITS + 1;
   localparam int REM_BITS       = $clog2(MATCH_DISTANCE + 1);
   localparam int DIST_BITS      = $clog2(MATCH_DISTANCE + 1);
   localparam int PAIR_MIN       = 4;
   localparam int LONG_LEN       = 5;
   localparam int SHORT_LEN      = 4;

   localparam logic [SIZE_BITS-1:0] SIZE_CAP = SIZE_BITS'(1) << OFFSET_BITS;

   // byte patterns, element 0 is the lowest address
   localparam logic [7:0] PAT_LONG  [0:LONG_LEN-1]  = '{8'h0F, 8'hBA, 8'hE0, 8'h0E, 8'h72};
   localparam logic [7:0] PAT_SHORT [0:SHORT_LEN-1] = '{8'hF6, 8'hC4, 8'h40, 8'h75};
   localparam logic [7:0] PAT_PAIR  [0:SHORT_LEN-1] = '{8'h01, 8'h40, 8'h00, 8'h00};

   // patch lengths
   localparam logic [2:0] PLEN_NONE  = 3'd0;
   localparam logic [2:0] PLEN_LONG  = 3'd6;
   localparam logic [2:0] PLEN_SHORT = 3'd5;
   localparam logic [2:0] PLEN_PAIR  = 3'd4;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_LONG  = 2'd1,
      KIND_SHORT = 2'd2,
      KIND_PAIR  = 2'd3
   } kind_type;

   // sliding window, index 0 is the oldest byte
   typedef logic [WIN-1:0][7:0] window_type;

   // control carried with the window into the match stage
   typedef struct packed {
      logic                   valid;
      logic                   last;
      logic                   judge;
      logic [OFFSET_BITS-1:0] pos;
      logic [REM_BITS-1:0]    remain;
   } stage_type;

   // outcome of the pattern tests for one candidate
   typedef struct packed {
      logic                 hit;
      kind_type             kind;
      logic [DIST_BITS-1:0] spacing;
   } hit_type;

   function automatic logic [2:0] patch_len(kind_type kind);
      logic [2:0] len;
      case (kind)
         KIND_LONG:  len = PLEN_LONG;
         KIND_SHORT: len = PLEN_SHORT;
         KIND_PAIR:  len = PLEN_PAIR;
         default:    len = PLEN_NONE;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- design/smcpf_match.sv -----
// ----------------------------------------------------------------------------
// smcpf_match
// parallel pattern tests over the byte window for one candidate offset
// ----------------------------------------------------------------------------
`default_nettype none

module smcpf_match (
   input  smcpf_pkg::window_type                window,
   input  logic [smcpf_pkg::REM_BITS-1:0]       remain,
   output smcpf_pkg::hit_type                   hit
);

   logic [smcpf_pkg::LONG_LEN-1:0]   long_eq;
   logic [smcpf_pkg::SHORT_LEN-1:0]  short_eq;
   logic [smcpf_pkg::SHORT_LEN-1:0]  head_eq;
   logic [smcpf_pkg::MATCH_DISTANCE:0] pair_at;
   logic                              pair_found;
   logic [smcpf_pkg::DIST_BITS-1:0]   pair_dist;
   logic                              long_ok;
   logic                              short_ok;
   logic                              head_ok;

   // byte compares at the candidate offset
   always_comb begin
      for (int i = 0; i < smcpf_pkg::LONG_LEN; i++) begin
         long_eq[i] = (window[i] == smcpf_pkg::PAT_LONG[i]);
      end
      for (int i = 0; i < smcpf_pkg::SHORT_LEN; i++) begin
         short_eq[i] = (window[i] == smcpf_pkg::PAT_SHORT[i]);
         head_eq[i]  = (window[i] == smcpf_pkg::PAT_PAIR[i]);
      end
   end

   // long pattern needs one more byte inside the scan range
   assign long_ok  = (&long_eq) && (remain != '0);
   assign short_ok = &short_eq;
   assign head_ok  = &head_eq;

   // second pair pattern at each distance that stays inside the range
   always_comb begin
      pair_at = '0;
      for (int k = smcpf_pkg::PAIR_MIN; k <= smcpf_pkg::MATCH_DISTANCE; k++) begin
         pair_at[k] = (remain >= smcpf_pkg::REM_BITS'(k));
         for (int j = 0; j < smcpf_pkg::SHORT_LEN; j++) begin
            pair_at[k] = pair_at[k] && (window[k+j] == smcpf_pkg::PAT_PAIR[j]);
         end
      end
   end

   // nearest second pattern wins
   always_comb begin
      pair_found = 1'b0;
      pair_dist  = '0;
      for (int k = smcpf_pkg::MATCH_DISTANCE; k >= smcpf_pkg::PAIR_MIN; k--) begin
         if (pair_at[k]) begin
            pair_found = 1'b1;
            pair_dist  = smcpf_pkg::DIST_BITS'(k);
         end
      end
   end

   // test priority: long, short, pair
   always_comb begin
      hit.hit     = 1'b1;
      hit.kind    = smcpf_pkg::KIND_NONE;
      hit.spacing = '0;
      if (long_ok) begin
         hit.kind = smcpf_pkg::KIND_LONG;
      end else if (short_ok) begin
         hit.kind = smcpf_pkg::KIND_SHORT;
      end else if (head_ok && pair_found) begin
         hit.kind    = smcpf_pkg::KIND_PAIR;
         hit.spacing = pair_dist;
      end else begin
         hit.hit  = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- design/smcpf_front.sv -----
// ----------------------------------------------------------------------------
// smcpf_front
// size register, byte counter and input window register stage
// ----------------------------------------------------------------------------
`default_nettype none

module smcpf_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [smcpf_pkg::SIZE_BITS-1:0]    csr_image_size,
   input  logic                               req_take,
   input  logic                               hold,
   input  logic [7:0]                         req_byte_value,
   output smcpf_pkg::window_type              window,
   output smcpf_pkg::stage_type               stage
);

   `include "safe_mode_check_pattern_finder_top_macros.svh"

   logic [smcpf_pkg::SIZE_BITS-1:0]   size_ff;
   logic [smcpf_pkg::SIZE_BITS-1:0]   size_in;
   logic [smcpf_pkg::OFFSET_BITS-1:0] count_ff;
   logic [smcpf_pkg::OFFSET_BITS-1:0] count_in;
   logic [smcpf_pkg::SIZE_BITS-1:0]   count_next;
   logic [smcpf_pkg::SIZE_BITS-1:0]   remain_full;
   logic                              size_zero;
   logic                              take;
   logic                              last;
   smcpf_pkg::window_type             window_ff;
   smcpf_pkg::window_type             window_in;
   smcpf_pkg::stage_type              stage_ff;
   smcpf_pkg::stage_type              stage_in;

   // image size, clamped to the offset range
   assign size_in = (csr_image_size > smcpf_pkg::SIZE_CAP) ? smcpf_pkg::SIZE_CAP
                                                          : csr_image_size;
   assign size_zero = (size_ff == '0);

   // bytes of an empty image are dropped
   assign take = req_take && !size_zero;

   // position bookkeeping for the accepted byte
   assign count_next  = {1'b0, count_ff} + smcpf_pkg::SIZE_BITS'(1);
   assign last        = (count_next == size_ff);
   assign remain_full = size_ff - count_next;
   assign count_in    = last ? '0 : count_ff + smcpf_pkg::OFFSET_BITS'(1);

   // window shifts one byte per accepted request
   assign window_in = {req_byte_value, window_ff[smcpf_pkg::WIN-1:1]};

   // control for the match stage
   always_comb begin
      stage_in.valid  = take;
      stage_in.last   = last;
      stage_in.judge  = (count_next >= smcpf_pkg::SIZE_BITS'(smcpf_pkg::WIN));
      stage_in.pos    = count_ff - smcpf_pkg::OFFSET_BITS'(smcpf_pkg::WIN - 1);
      stage_in.remain = (remain_full > smcpf_pkg::SIZE_BITS'(smcpf_pkg::MATCH_DISTANCE))
                        ? smcpf_pkg::REM_BITS'(smcpf_pkg::MATCH_DISTANCE)
                        : remain_full[smcpf_pkg::REM_BITS-1:0];
   end

   // size and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= '0;
         count_ff <= '0;
      end else if (csr_write) begin
         size_ff  <= size_in;
         count_ff <= '0;
      end else if (take) begin
         count_ff <= count_in;
      end
   end

   // stage register, frozen while the match stage is held
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (!hold) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (take && !hold) begin
         window_ff        <= window_in;
         stage_ff.last    <= stage_in.last;
         stage_ff.judge   <= stage_in.judge;
         stage_ff.pos     <= stage_in.pos;
         stage_ff.remain  <= stage_in.remain;
      end
   end

   assign window = window_ff;
   assign stage  = stage_ff;

   `SMCPF_ASSERT_NOW(a_count_in_range, clock, reset, !size_zero,
      ({1'b0, count_ff} < size_ff), "byte counter reached the image size")
   `SMCPF_ASSERT_NOW(a_stage_needs_size, clock, reset, stage_ff.valid,
      !size_zero, "byte staged for an empty image")

endmodule

`default_nettype wire

// ----- design/safe_mode_check_pattern_finder_top.sv -----
// ----------------------------------------------------------------------------
// safe_mode_check_pattern_finder_top
// streaming search for the safe mode check patterns in a byte image
// ----------------------------------------------------------------------------
// Write the image size on the csr port first, then stream the image one byte
// per request; the block takes one byte every cycle unless req_stall is high.
// Each byte goes through an input register stage (counter and 20-byte window)
// and one stage of parallel byte compares; the result for an image is registered
// when its last byte is compared. Only a result that is still waiting when the
// next image ends makes req_stall rise. After the last byte the next image,
// of the same size, starts on its own; a size of zero drops all bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module safe_mode_check_pattern_finder_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_byte_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_match_kind,
   output logic [smcpf_pkg::OFFSET_BITS-1:0]   rsp_first_offset,
   output logic [smcpf_pkg::OFFSET_BITS-1:0]   rsp_second_offset,
   output logic [2:0]                          rsp_patch_length,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [smcpf_pkg::SIZE_BITS-1:0]     csr_image_size
);

   `include "safe_mode_check_pattern_finder_top_macros.svh"

   logic                              csr_write;
   logic                              hold;
   logic                              fire;
   logic                              new_hit;
   smcpf_pkg::window_type             window;
   smcpf_pkg::stage_type              stage;
   smcpf_pkg::hit_type                hit;

   logic                              latched_ff;
   smcpf_pkg::kind_type               kind_ff;
   logic [smcpf_pkg::OFFSET_BITS-1:0] first_ff;
   logic [smcpf_pkg::OFFSET_BITS-1:0] second_ff;
   smcpf_pkg::kind_type               kind_in;
   logic [smcpf_pkg::OFFSET_BITS-1:0] first_in;
   logic [smcpf_pkg::OFFSET_BITS-1:0] second_in;
   logic [smcpf_pkg::OFFSET_BITS-1:0] pair_pos;

   logic                              rsp_valid_ff;
   smcpf_pkg::kind_type               rsp_kind_ff;
   logic [smcpf_pkg::OFFSET_BITS-1:0] rsp_first_ff;
   logic [smcpf_pkg::OFFSET_BITS-1:0] rsp_second_ff;
   logic [2:0]                        rsp_plen_ff;

   // configuration is always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;

   // the last byte waits in the match stage while the result slot is full
   assign hold      = stage.valid && stage.last && rsp_valid_ff && rsp_stall;
   assign req_stall = hold;
   assign fire      = stage.valid && !hold;

   smcpf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_image_size (csr_image_size),
      .req_take       (req_valid && !req_stall),
      .hold           (hold),
      .req_byte_value (req_byte_value),
      .window         (window),
      .stage          (stage)
   );

   smcpf_match u_match (
      .window (window),
      .remain (stage.remain),
      .hit    (hit)
   );

   // a candidate counts only until the first match of the image
   assign new_hit  = stage.judge && !latched_ff && hit.hit;
   assign pair_pos = stage.pos
                     + {{(smcpf_pkg::OFFSET_BITS - smcpf_pkg::DIST_BITS){1'b0}}, hit.spacing};

   // earliest match so far, including this candidate
   always_comb begin
      kind_in   = kind_ff;
      first_in  = first_ff;
      second_in = second_ff;
      if (new_hit) begin
         kind_in   = hit.kind;
         first_in  = stage.pos;
         second_in = (hit.kind == smcpf_pkg::KIND_PAIR) ? pair_pos : '0;
      end
   end

   // match latch, cleared at the end of each image and on a size write
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         latched_ff <= 1'b0;
         kind_ff    <= smcpf_pkg::KIND_NONE;
         first_ff   <= '0;
         second_ff  <= '0;
      end else if (fire && stage.last) begin
         latched_ff <= 1'b0;
         kind_ff    <= smcpf_pkg::KIND_NONE;
         first_ff   <= '0;
         second_ff  <= '0;
      end else if (fire && new_hit) begin
         latched_ff <= 1'b1;
         kind_ff    <= kind_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && stage.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && stage.last) begin
         rsp_kind_ff   <= kind_in;
         rsp_first_ff  <= first_in;
         rsp_second_ff <= second_in;
         rsp_plen_ff   <= smcpf_pkg::patch_len(kind_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_kind    = rsp_kind_ff;
   assign rsp_first_offset  = rsp_first_ff;
   assign rsp_second_offset = rsp_second_ff;
   assign rsp_patch_length  = rsp_plen_ff;

   `SMCPF_ASSERT_NOW(a_latched_has_kind, clock, reset, latched_ff,
      kind_ff != smcpf_pkg::KIND_NONE, "match latched without a kind")
   `SMCPF_ASSERT_NOW(a_none_is_empty, clock, reset,
      rsp_valid_ff && (rsp_kind_ff == smcpf_pkg::KIND_NONE),
      (rsp_first_ff == '0) && (rsp_second_ff == '0) && (rsp_plen_ff == smcpf_pkg::PLEN_NONE),
      "empty result carries offsets")
   `SMCPF_ASSERT_NOW(a_pair_order, clock, reset,
      rsp_valid_ff && (rsp_kind_ff == smcpf_pkg::KIND_PAIR),
      (rsp_second_ff - rsp_first_ff) >= smcpf_pkg::OFFSET_BITS'(smcpf_pkg::PAIR_MIN),
      "pair result with overlapping patterns")
   `SMCPF_ASSERT_NEXT(a_result_from_last, clock, reset,
      fire && stage.last, rsp_valid_ff, "last byte gave no result")

endmodule

`default_nettype wire
